// ===== rtl/lfr_pkg.sv =====
// shared types and constants of the longest free run finder
`timescale 1ns / 1ps

package lfr_pkg;

    // widest slot index or bound the design supports (up to 8191 slots)
    localparam int SLOT_W = 13;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int DAY_LENGTH_W = 10;
    localparam logic [DAY_LENGTH_W-1:0] DAY_LENGTH_RESET = 10'd480;
    localparam logic REG_DAY_LENGTH = 1'b0;

    // item payload widths
    localparam int CMD_W = 1;
    localparam int BOUND_W = 10;
    localparam int FREE_START_W = 9;
    localparam int FREE_LENGTH_W = 10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BUSY = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    // classified operation handed from front to back
    typedef struct packed {
        logic              query;
        logic [SLOT_W-1:0] lo;
        logic [SLOT_W-1:0] hi;
    } op_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_MARK,
        BK_SCAN,
        BK_DRAIN,
        BK_FINISH
    } back_state_t;

endpackage

// ===== rtl/lfr_req_if.sv =====
// request channel: busy interval or query item
`timescale 1ns / 1ps

interface lfr_req_if
    import lfr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [BOUND_W-1:0]   busy_start;
    logic [BOUND_W-1:0]   busy_end;

    modport source (
        output valid,
        output cmd,
        output busy_start,
        output busy_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  busy_start,
        input  busy_end,
        output ready
    );
endinterface

// ===== rtl/lfr_rsp_if.sv =====
// response channel: longest free run result item
`timescale 1ns / 1ps

interface lfr_rsp_if
    import lfr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FREE_START_W-1:0]  free_start;
    logic [FREE_LENGTH_W-1:0] free_length;

    modport source (
        output valid,
        output free_start,
        output free_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  free_start,
        input  free_length,
        output ready
    );
endinterface

// ===== rtl/lfr_front.sv =====
// front end: accepts items, clips bounds to the window and classifies them
`timescale 1ns / 1ps

module lfr_front
    import lfr_pkg::*;
#(
    parameter int SLOTS = 512
) (
    lfr_req_if.sink                  req,
    input  logic [DAY_LENGTH_W-1:0]  day_length,
    input  logic                     back_ready,
    input  logic                     q_full,
    output logic                     q_push,
    output op_t                      q_op
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int BW = (CW > BOUND_W) ? CW : BOUND_W;
    localparam int DW = (BW > DAY_LENGTH_W) ? BW : DAY_LENGTH_W;

    logic [DW-1:0] len_wide;
    logic [BW-1:0] win_len;
    logic [BW-1:0] start_ext;
    logic [BW-1:0] end_ext;
    logic [BW-1:0] start_clip;
    logic [BW-1:0] end_clip;
    logic          is_query;
    logic          has_span;

    // effective window length, saturated at the map size
    assign len_wide = (DW'(day_length) < DW'(SLOTS)) ? DW'(day_length) : DW'(SLOTS);
    assign win_len  = BW'(len_wide);

    // clip both bounds to the window
    assign start_ext  = BW'(req.busy_start);
    assign end_ext    = BW'(req.busy_end);
    assign start_clip = (start_ext > win_len) ? win_len : start_ext;
    assign end_clip   = (end_ext > win_len) ? win_len : end_ext;

    // classify: queries always go through, empty spans are dropped here
    assign is_query = (req.cmd == CMD_QUERY);
    assign has_span = (start_clip < end_clip);

    assign req.ready = back_ready && !q_full;
    assign q_push    = req.valid && req.ready && (is_query || has_span);

    always_comb
    begin
        q_op.query = is_query;
        q_op.lo    = SLOT_W'(start_clip);
        q_op.hi    = is_query ? SLOT_W'(win_len) : SLOT_W'(end_clip);
    end

endmodule

// ===== rtl/lfr_queue.sv =====
// short queue of classified operations between front and back
`timescale 1ns / 1ps

module lfr_queue
    import lfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/lfr_back.sv =====
// back end: occupancy memory, mark and scan sequencer, result register
`timescale 1ns / 1ps

module lfr_back
    import lfr_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        head_op,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       init_done,
    lfr_rsp_if.source  rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // occupancy memory, one bit per slot
    logic          occ_mem [SLOTS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          rd_data_reg;

    back_state_t   state_reg;
    back_state_t   state_next;

    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [CW-1:0] bound_reg;
    logic [CW-1:0] bound_next;
    logic          rd_valid_reg;
    logic          rd_valid_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;

    logic [CW-1:0] run_len_reg;
    logic [CW-1:0] run_len_next;
    logic [AW-1:0] run_start_reg;
    logic [AW-1:0] run_start_next;
    logic [CW-1:0] best_len_reg;
    logic [CW-1:0] best_len_next;
    logic [AW-1:0] best_start_reg;
    logic [AW-1:0] best_start_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [FREE_START_W-1:0]  out_start_reg;
    logic [FREE_START_W-1:0]  out_start_next;
    logic [FREE_LENGTH_W-1:0] out_length_reg;
    logic [FREE_LENGTH_W-1:0] out_length_next;

    logic          ptr_last;
    logic          mark_last;
    logic          out_free;
    logic          in_window;
    logic [CW-1:0] final_len;
    logic [AW-1:0] final_start;

    assign ptr_last  = (ptr_reg == AW'(SLOTS - 1));
    assign mark_last = ((CW'(ptr_reg) + CW'(1)) == bound_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_window = (CW'(rd_idx_reg) < bound_reg);
    assign init_done = (state_reg != BK_INIT);

    // closing run against the best one so far
    assign final_len   = (run_len_reg > best_len_reg) ? run_len_reg : best_len_reg;
    assign final_start = (run_len_reg > best_len_reg) ? run_start_reg : best_start_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_INIT:
            begin
                if (ptr_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = head_op.query ? BK_SCAN : BK_MARK;
                end
            end
            BK_MARK:
            begin
                if (mark_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCAN:
            begin
                if (ptr_last)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_INIT;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = 1'b0;
        ptr_next        = ptr_reg;
        bound_next      = bound_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = ptr_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_start_next  = out_start_reg;
        out_length_next = out_length_reg;

        // run tracking on the slot read in the previous cycle
        if (rd_valid_reg && in_window)
        begin
            if (!rd_data_reg)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = rd_idx_reg;
                end
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                if (run_len_reg > best_len_reg)
                begin
                    best_len_next   = run_len_reg;
                    best_start_next = run_start_reg;
                end
                run_len_next = '0;
            end
        end

        case (state_reg)
            BK_INIT:
            begin
                // clearing pass over the whole map
                mem_we   = 1'b1;
                ptr_next = ptr_last ? '0 : ptr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    bound_next = CW'(head_op.hi);
                    if (head_op.query)
                    begin
                        ptr_next        = '0;
                        run_len_next    = '0;
                        run_start_next  = '0;
                        best_len_next   = '0;
                        best_start_next = '0;
                    end
                    else
                    begin
                        ptr_next = AW'(head_op.lo);
                    end
                end
            end
            BK_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                ptr_next  = ptr_reg + 1'b1;
            end
            BK_SCAN:
            begin
                // read each slot and clear it in the same cycle
                mem_we        = 1'b1;
                rd_valid_next = 1'b1;
                ptr_next      = ptr_last ? '0 : ptr_reg + 1'b1;
            end
            BK_DRAIN:
            begin
                rd_valid_next = 1'b0;
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_start_next  = FREE_START_W'(final_start);
                    out_length_next = FREE_LENGTH_W'(final_len);
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bound_reg      <= bound_next;
        rd_idx_reg     <= rd_idx_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        out_start_reg  <= out_start_next;
        out_length_reg <= out_length_next;
    end

    // occupancy memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= occ_mem[ptr_reg];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.free_start  = out_start_reg;
    assign rsp.free_length = out_length_reg;

endmodule

// ===== rtl/longest_free_run_finder_unit.sv =====
// top level of the longest free run finder
`timescale 1ns / 1ps

//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------------
//  req     | in  | valid / ready  | cmd, busy_start, busy_end
//  rsp     | out | valid / ready  | free_start, free_length
//  apb     | in  | psel / penable | paddr, pwdata, prdata (day_length)
//
//  a busy item is dispatched from idle, then marks one slot per cycle
//  a query scans all SLOTS memory entries, then drains the last read and finishes
//  the scan rate is set by the single read port of the occupancy memory
//  after reset a clearing pass over all SLOTS entries runs before req.ready rises
//  a two-entry queue lets items be taken while the back end marks or scans;
//  a result waits in the output register while a stalled rsp holds it

module longest_free_run_finder_unit
    import lfr_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lfr_req_if.sink                req,
    lfr_rsp_if.source              rsp,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [DAY_LENGTH_W-1:0] day_length_reg;
    logic [DAY_LENGTH_W-1:0] day_length_next;
    logic                    reg_sel;
    logic                    cfg_write;
    logic                    back_ready;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_push;
    logic                    q_pop;
    op_t                     q_push_op;
    op_t                     q_head_op;

    // configuration register
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == REG_DAY_LENGTH);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        day_length_next = day_length_reg;
        if (cfg_write)
        begin
            day_length_next = pwdata[DAY_LENGTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_length_reg <= DAY_LENGTH_RESET;
        end
        else
        begin
            day_length_reg <= day_length_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(day_length_reg) : '0;

    // front end
    lfr_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .req        (req),
        .day_length (day_length_reg),
        .back_ready (back_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_push_op)
    );

    // operation queue
    lfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .head_op (q_head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    // back end
    lfr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (q_head_op),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .init_done (back_ready),
        .rsp       (rsp)
    );

    // no item is taken during the clearing pass
    a_no_accept_in_init: assert property (
        @(posedge clk) disable iff (!rst_n)
        !back_ready |-> !req.ready
    ) else $error("item accepted during clearing pass");

    // the front never pushes into a full queue
    a_no_queue_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full
    ) else $error("queue overflow");

    // an empty result reports start zero
    a_empty_result_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.free_length == '0)) |-> (rsp.free_start == '0)
    ) else $error("nonzero start with zero length");

    // a queued item leaves the queue only from the idle back end
    a_pop_not_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_empty && back_ready)
    ) else $error("pop from empty queue or during clearing pass");

endmodule
